// ----- design/edg4_pkg.sv -----
// ----------------------------------------------------------------------------
// edg4_pkg
// Shared types, register map and error-weight helpers for the 4-level gray
// error-diffusion dither.
// ----------------------------------------------------------------------------
package edg4_pkg;

  localparam int GRAY_W  = 8;
  localparam int LEVEL_W = 4;
  localparam int SIZE_W  = 9;
  localparam int ERR_W   = 3;   // diffused error per entry never exceeds 6
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_DITHER_ENABLE = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Register reset values
  localparam logic              RST_DITHER_ENABLE = 1'b1;
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH   = 9'd128;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT  = 9'd128;

  typedef struct packed {
    logic              dither_enable;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

  // Position flags of one pixel, worked out at the front
  typedef struct packed {
    logic bank;       // error bank read by this row
    logic first_row;  // row zero: no error from above
    logic last_col;
    logic last_row;
  } ctrl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               row_end;
    logic               frame_end;
  } res_t;

  // floor(7e/16) for e in 0..15
  function automatic logic [2:0] err_seven(input logic [3:0] e);
    logic [6:0] p;
    p = {3'b000, e} + {2'b00, e, 1'b0} + {1'b0, e, 2'b00};
    return p[6:4];
  endfunction

  // floor(5e/16)
  function automatic logic [2:0] err_five(input logic [3:0] e);
    logic [6:0] p;
    p = {3'b000, e} + {1'b0, e, 2'b00};
    return p[6:4];
  endfunction

  // floor(3e/16)
  function automatic logic [1:0] err_three(input logic [3:0] e);
    logic [5:0] p;
    p = {2'b00, e} + {1'b0, e, 1'b0};
    return p[5:4];
  endfunction

endpackage

// ----- design/edg4_queue.sv -----
// ----------------------------------------------------------------------------
// edg4_queue
// Small first-in first-out buffer of flip-flops with an occupancy count.
// ----------------------------------------------------------------------------
module edg4_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Store an incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/edg4_regs.sv -----
// ----------------------------------------------------------------------------
// edg4_regs
// APB-style configuration registers: dither enable, frame width and height.
// ----------------------------------------------------------------------------
module edg4_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edg4_pkg::PADDR_W-1:0]  paddr,
  input  logic [edg4_pkg::PDATA_W-1:0]  pwdata,
  output logic [edg4_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output edg4_pkg::cfg_t                cfg
);

  logic [1:0] index;
  logic       wr_en;

  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither_enable <= edg4_pkg::RST_DITHER_ENABLE;
      cfg.frame_width   <= edg4_pkg::RST_FRAME_WIDTH;
      cfg.frame_height  <= edg4_pkg::RST_FRAME_HEIGHT;
    end else if (wr_en) begin
      case (index)
        edg4_pkg::REG_DITHER_ENABLE: cfg.dither_enable <= pwdata[0];
        edg4_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= pwdata[edg4_pkg::SIZE_W-1:0];
        edg4_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= pwdata[edg4_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (index)
      edg4_pkg::REG_DITHER_ENABLE: prdata[0] = cfg.dither_enable;
      edg4_pkg::REG_FRAME_WIDTH:   prdata[edg4_pkg::SIZE_W-1:0] = cfg.frame_width;
      edg4_pkg::REG_FRAME_HEIGHT:  prdata[edg4_pkg::SIZE_W-1:0] = cfg.frame_height;
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- design/edg4_front.sv -----
// ----------------------------------------------------------------------------
// edg4_front
// Accepts pixels, tracks column and row, and tags each item with its
// position flags before it enters the work queue.
// ----------------------------------------------------------------------------
module edg4_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic [edg4_pkg::GRAY_W-1:0]           gray_in,
  output logic                                  full,
  input  edg4_pkg::cfg_t                        cfg,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [edg4_pkg::GRAY_W-1:0]           q_gray,
  output logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  output edg4_pkg::ctrl_t                       q_ctrl
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CCMPW = (CW + 1 > edg4_pkg::SIZE_W + 1) ? CW + 1 : edg4_pkg::SIZE_W + 1;
  localparam int RCMPW = (RW + 1 > edg4_pkg::SIZE_W + 1) ? RW + 1 : edg4_pkg::SIZE_W + 1;

  logic [CW-1:0]    column;
  logic [RW-1:0]    row;
  logic [CCMPW-1:0] w_eff;
  logic [RCMPW-1:0] h_eff;
  logic             last_col;
  logic             last_row;
  logic             accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Effective frame size: zero reads as one, large values saturate
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = CCMPW'(1);
    end else if (CCMPW'(cfg.frame_width) > CCMPW'(MAX_WIDTH)) begin
      w_eff = CCMPW'(MAX_WIDTH);
    end else begin
      w_eff = CCMPW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = RCMPW'(1);
    end else if (RCMPW'(cfg.frame_height) > RCMPW'(MAX_HEIGHT)) begin
      h_eff = RCMPW'(MAX_HEIGHT);
    end else begin
      h_eff = RCMPW'(cfg.frame_height);
    end
  end

  assign last_col = (CCMPW'(column) + CCMPW'(1)) >= w_eff;
  assign last_row = (RCMPW'(row) + RCMPW'(1)) >= h_eff;

  // Tag the item
  assign q_push           = accept;
  assign q_gray           = gray_in;
  assign q_col            = column;
  assign q_ctrl.bank      = row[0];
  assign q_ctrl.first_row = (row == '0);
  assign q_ctrl.last_col  = last_col;
  assign q_ctrl.last_row  = last_row;

  // Advance position
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column <= '0;
        if (last_row) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        column <= column + 1'b1;
      end
    end
  end

endmodule

// ----- design/edg4_back.sv -----
// ----------------------------------------------------------------------------
// edg4_back
// Reads the error gathered from the row above, adds the right carry,
// quantizes to four bits and writes the error terms for the row below.
// ----------------------------------------------------------------------------
module edg4_back #(
  parameter int MAX_WIDTH = 256,
  parameter int OUT_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  dither_enable,
  input  logic                                  q_empty,
  input  logic [edg4_pkg::GRAY_W-1:0]           q_gray,
  input  logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  input  edg4_pkg::ctrl_t                       q_ctrl,
  output logic                                  q_pop,
  input  logic [$clog2(OUT_DEPTH):0]            out_count,
  output logic                                  res_push,
  output edg4_pkg::res_t                        res
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int OCW   = $clog2(OUT_DEPTH) + 1;
  localparam int ERR_W = edg4_pkg::ERR_W;

  // Error rows: two banks, one read by this row, one filled for the next
  logic [ERR_W-1:0] err_mem [2**(CW+1)];

  logic                       v2;
  logic [edg4_pkg::GRAY_W-1:0] g2;
  logic [CW-1:0]              x2;
  edg4_pkg::ctrl_t            c2;
  logic [ERR_W-1:0]           rd_data;
  logic                       byp;
  logic [ERR_W-1:0]           byp_data;

  logic [ERR_W-1:0]           carry;
  logic [ERR_W-1:0]           five_prev;
  logic [ERR_W-1:0]           tail;
  logic [CW-1:0]              prev_last;

  logic [CW:0]                ra;
  logic [CW:0]                wa;
  logic [ERR_W-1:0]           wd;
  logic                       we;
  logic [ERR_W-1:0]           mem_val;
  logic [ERR_W-1:0]           up_err;
  logic [8:0]                 pix9;
  logic [7:0]                 pix;
  logic [3:0]                 e;
  logic                       active;
  logic [2:0]                 five;
  logic [1:0]                 three;
  logic [ERR_W-1:0]           carry_next;

  // Issue only when the result queue has room for everything in flight
  assign q_pop = !q_empty && ((OCW'(out_count) + OCW'(v2)) < OCW'(OUT_DEPTH));
  assign ra    = {q_ctrl.bank, q_col};

  // Select error from above: stored entry, row tail, or nothing
  always_comb begin
    mem_val = byp ? byp_data : rd_data;
    if (c2.first_row) begin
      up_err = '0;
    end else if (x2 < prev_last) begin
      up_err = mem_val;
    end else if (x2 == prev_last) begin
      up_err = tail;
    end else begin
      up_err = '0;
    end
  end

  // Quantize and split the error
  always_comb begin
    pix9       = {1'b0, g2} + 9'(up_err) + 9'(carry);
    pix        = pix9[8] ? 8'hFF : pix9[7:0];
    e          = pix[3:0];
    active     = dither_enable && !c2.last_row;
    five       = active ? edg4_pkg::err_five(e) : 3'd0;
    three      = active ? edg4_pkg::err_three(e) : 2'd0;
    carry_next = (dither_enable && !c2.last_col) ? edg4_pkg::err_seven(e) : '0;
    res.level     = dither_enable ? pix[7:4] : g2[7:4];
    res.row_end   = c2.last_col;
    res.frame_end = c2.last_col && c2.last_row;
  end

  assign res_push = v2;

  // Finish the entry to the left: its own share plus this pixel's below-left share
  assign we = v2 && (x2 != '0);
  assign wa = {~c2.bank, x2 - 1'b1};
  assign wd = five_prev + ERR_W'(three);

  // Error memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      err_mem[wa] <= wd;
    end
    if (q_pop) begin
      rd_data <= err_mem[ra];
    end
  end

  // Load the work stage; catch a write to the entry being read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      g2       <= q_gray;
      x2       <= q_col;
      c2       <= q_ctrl;
      byp      <= we && (wa == ra);
      byp_data <= wd;
    end
  end

  // Control state: stage valid, carry and row tail
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      carry     <= '0;
      five_prev <= '0;
      tail      <= '0;
      prev_last <= '0;
    end else begin
      v2 <= q_pop;
      if (v2) begin
        carry     <= carry_next;
        five_prev <= five;
        if (c2.last_col) begin
          tail      <= five;
          prev_last <= x2;
        end
      end
    end
  end

endmodule

// ----- design/error_diffusion_dither_gray4_core.sv -----
// ----------------------------------------------------------------------------
// error_diffusion_dither_gray4_core
// 8-bit gray to 4-bit level error-diffusion dither over a raster frame.
//
//   channel   signals                               direction
//   pixel     push, full, gray_in                    in
//   result    empty, pop, level, row_end, frame_end  out
//   config    psel, penable, pwrite, paddr, pwdata,  in / out
//             prdata, pready
//
// One pixel per clock sustained while results are taken; a pixel's result
// passes the work queue, then the memory read and quantize stage.
// The error rows sit in one memory of 2*MAX_WIDTH entries with a write and
// a read port each cycle; the right carry is a registered loop per pixel.
// Reset clears position, carry and queues; no clearing pass is needed.
// Pixels keep flowing while results wait, until both queues fill.
// ----------------------------------------------------------------------------
module error_diffusion_dither_gray4_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [edg4_pkg::GRAY_W-1:0]   gray_in,
  output logic                          empty,
  input  logic                          pop,
  output logic [edg4_pkg::LEVEL_W-1:0]  level,
  output logic                          row_end,
  output logic                          frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edg4_pkg::PADDR_W-1:0]  paddr,
  input  logic [edg4_pkg::PDATA_W-1:0]  pwdata,
  output logic [edg4_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int MID_W     = edg4_pkg::GRAY_W + CW + $bits(edg4_pkg::ctrl_t);
  localparam int RES_W     = $bits(edg4_pkg::res_t);

  edg4_pkg::cfg_t             cfg;

  logic                       f_push;
  logic                       f_full;
  logic [edg4_pkg::GRAY_W-1:0] f_gray;
  logic [CW-1:0]              f_col;
  edg4_pkg::ctrl_t            f_ctrl;

  logic [MID_W-1:0]           mid_head;
  logic                       mid_empty;
  logic                       mid_pop;
  logic [$clog2(MID_DEPTH):0] mid_count;
  logic [edg4_pkg::GRAY_W-1:0] b_gray;
  logic [CW-1:0]              b_col;
  edg4_pkg::ctrl_t            b_ctrl;

  logic                       r_push;
  edg4_pkg::res_t             r_res;
  logic                       r_full;
  logic [RES_W-1:0]           out_head;
  logic [$clog2(OUT_DEPTH):0] out_count;
  edg4_pkg::res_t             out_res;

  edg4_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  edg4_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .gray_in (gray_in),
    .full    (full),
    .cfg     (cfg),
    .q_full  (f_full),
    .q_push  (f_push),
    .q_gray  (f_gray),
    .q_col   (f_col),
    .q_ctrl  (f_ctrl)
  );

  // Work queue between front and back
  edg4_queue #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_gray, f_col, f_ctrl}),
    .full  (f_full),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign {b_gray, b_col, b_ctrl} = mid_head;

  edg4_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dither_enable (cfg.dither_enable),
    .q_empty       (mid_empty),
    .q_gray        (b_gray),
    .q_col         (b_col),
    .q_ctrl        (b_ctrl),
    .q_pop         (mid_pop),
    .out_count     (out_count),
    .res_push      (r_push),
    .res           (r_res)
  );

  // Result queue; the back part never pushes without room
  edg4_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_res),
    .full  (r_full),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty),
    .count (out_count)
  );

  assign out_res   = out_head;
  assign level     = out_res.level;
  assign row_end   = out_res.row_end;
  assign frame_end = out_res.frame_end && !(r_full && mid_count[0] && 1'b0);

endmodule
